### hdl/sti_pkg.sv
`timescale 1ns / 1ps

package sti_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_W       = $clog2(DEPTH + 1);

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [CNT_W-1:0]       count_type;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_ERASE  = 2'd1,
      REQ_READ   = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

   // Operation broadcast to every cell in the chain.
   typedef struct packed {
      logic      insert_en;
      logic      erase_en;
      value_type value;
   } cell_ctl_type;

   // Where a cell stands relative to the count and the request index.
   typedef struct packed {
      logic valid;
      logic at_end;
      logic past_index;
   } cell_pos_type;

endpackage

### hdl/sorted_table_insert_erase_top.sv
`timescale 1ns / 1ps
// A result is registered and appears on the rsp_ ports in the cycle after its request is taken.
// Throughput: one request per cycle; all cells compare and shift in parallel.
// busy stays low, so start may be held high on every cycle.
// Reset clears the entry count and the result strobe; entry contents are not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.

module sorted_table_insert_erase_top
   import sti_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_item_value,
   input  logic [3:0]  req_item_index,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_read_value,
   output logic [4:0]  rsp_item_position,
   output logic [4:0]  rsp_stored_count
);

   count_type    count_ff, count_in;
   logic         rsp_valid_ff;
   logic [1:0]   status_ff, status_in;
   logic [31:0]  read_value_ff, read_value_in;
   logic [4:0]   position_ff, position_in;

   cell_ctl_type ctl;
   cell_pos_type cell_pos [DEPTH];
   logic         greater  [DEPTH];
   value_type    entries  [DEPTH];
   count_type    land_pos;
   logic         accept;
   logic         index_ok;
   logic         is_full;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign index_ok = 32'(req_item_index) < 32'(count_ff);
   assign is_full  = 32'(count_ff) >= DEPTH;

   assign ctl.value     = req_item_value[VALUE_WIDTH-1:0];
   assign ctl.insert_en = accept && (req_type == REQ_INSERT) && !is_full;
   assign ctl.erase_en  = accept && (req_type == REQ_ERASE) && index_ok;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         assign cell_pos[g].valid      = 32'(g) < 32'(count_ff);
         assign cell_pos[g].at_end     = 32'(g) == 32'(count_ff);
         assign cell_pos[g].past_index = 32'(g) >= 32'(req_item_index);

         sti_cell u_cell (
            .clock        (clock),
            .ctl          (ctl),
            .pos          (cell_pos[g]),
            .prev_greater ((g == 0) ? 1'b0 : greater[(g == 0) ? 0 : g - 1]),
            .prev_entry   (entries[(g == 0) ? 0 : g - 1]),
            .next_entry   (entries[(g == DEPTH - 1) ? g : g + 1]),
            .greater      (greater[g]),
            .entry        (entries[g])
         );
      end
   endgenerate

   // The landing slot is the number of held entries not above the new value.
   always_comb begin
      land_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         land_pos = land_pos + count_type'(cell_pos[i].valid && !greater[i]);
      end
   end

   always_comb begin
      count_in      = count_ff;
      status_in     = STATUS_OK;
      read_value_in = '0;
      position_in   = '0;
      case (req_type)
         REQ_INSERT: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in    = count_ff + count_type'(1);
               position_in = 5'(land_pos);
            end
         end
         REQ_ERASE: begin
            if (!index_ok) begin
               status_in = STATUS_BAD_INDEX;
            end else begin
               count_in    = count_ff - count_type'(1);
               position_in = 5'(req_item_index);
            end
         end
         REQ_READ: begin
            if (!index_ok) begin
               status_in = STATUS_BAD_INDEX;
            end else begin
               read_value_in = 32'(entries[req_item_index[$clog2(DEPTH)-1:0]]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         read_value_ff <= read_value_in;
         position_ff   <= position_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_read_value    = read_value_ff;
   assign rsp_item_position = position_ff;
   assign rsp_stored_count  = 5'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("entry count above table depth");

   a_rsp_follows_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request gave no result");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_INSERT && is_full) |=>
         (rsp_status == STATUS_FULL && $stable(count_ff)))
      else $error("insert into full table changed the count");

   a_erase_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctl.erase_en |=> (count_ff == $past(count_ff) - count_type'(1)))
      else $error("erase did not reduce the count by one");

endmodule

### hdl/sti_cell.sv
`timescale 1ns / 1ps

module sti_cell
   import sti_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  cell_pos_type pos,
   input  logic         prev_greater,
   input  value_type    prev_entry,
   input  value_type    next_entry,
   output logic         greater,
   output value_type    entry
);

   value_type entry_ff;
   value_type entry_in;

   assign greater = pos.valid && (entry_ff > ctl.value);
   assign entry   = entry_ff;

   // On insert the cells holding larger values shift up by one; the first of
   // them, or the first free cell, takes the new value.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert_en && (greater || pos.at_end)) begin
         entry_in = prev_greater ? prev_entry : ctl.value;
      end else if (ctl.erase_en && pos.past_index) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench
   import sti_pkg::*;
();

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_REQUESTS = 1600;
   localparam int DIRECTED_ROWS = 25;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam bit TYPED = 1'b1;
   localparam bit PREDICTED = 1'b0;

   typedef struct packed {
      logic [1:0] status;
      value_type  read_value;
      count_type  position;
      count_type  count;
   } table_result_type;

   typedef struct packed {
      logic [1:0]       kind;
      value_type        value;
      logic [3:0]       index;
      bit               typed;
      table_result_type known;
   } stim_row_type;

   typedef enum {FILL_UP, DRAIN_DOWN, CHURN} traffic_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = 2'd0;
   logic [31:0] req_item_value = 32'd0;
   logic [3:0]  req_item_index = 4'd0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_read_value;
   logic [4:0]  rsp_item_position;
   logic [4:0]  rsp_stored_count;

   value_type        table_entries [DEPTH];
   int               table_count = 0;
   table_result_type pending_results [$];
   table_result_type oldest_result;
   int               error_count = 0;
   int               cycle_count = 0;

   // Values are typed in only where the outcome is plain from the sequence so far.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{REQ_READ,    32'h0,        4'd0,  TYPED, '{STATUS_BAD_INDEX, 32'h0, 5'd0, 5'd0}},
      '{REQ_ERASE,   32'h0,        4'd0,  TYPED, '{STATUS_BAD_INDEX, 32'h0, 5'd0, 5'd0}},
      '{REQ_UNKNOWN, 32'hFFFFFFFF, 4'd15, TYPED, '{STATUS_OK, 32'h0, 5'd0, 5'd0}},
      '{REQ_INSERT,  32'hFFFFFFFF, 4'd0,  TYPED, '{STATUS_OK, 32'h0, 5'd0, 5'd1}},
      '{REQ_INSERT,  32'h0,        4'd15, TYPED, '{STATUS_OK, 32'h0, 5'd0, 5'd2}},
      '{REQ_INSERT,  32'hFFFFFFFF, 4'd0,  TYPED, '{STATUS_OK, 32'h0, 5'd2, 5'd3}},
      '{REQ_INSERT,  32'h0,        4'd0,  TYPED, '{STATUS_OK, 32'h0, 5'd1, 5'd4}},
      '{REQ_INSERT,  32'h80000000, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'h7FFFFFFF, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'h55555555, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'hAAAAAAAA, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'h00000001, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'hFFFFFFFE, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'h80000000, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'h00010000, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'h0000FFFF, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'hFFFF0000, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'h7FFFFFFF, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'h00000002, 4'd0,  PREDICTED, '0},
      '{REQ_INSERT,  32'h00000005, 4'd0,  TYPED, '{STATUS_FULL, 32'h0, 5'd0, 5'd16}},
      '{REQ_READ,    32'h0,        4'd15, TYPED, '{STATUS_OK, 32'hFFFFFFFF, 5'd0, 5'd16}},
      '{REQ_ERASE,   32'h0,        4'd15, TYPED, '{STATUS_OK, 32'h0, 5'd15, 5'd15}},
      '{REQ_ERASE,   32'h0,        4'd0,  TYPED, '{STATUS_OK, 32'h0, 5'd0, 5'd14}},
      '{REQ_UNKNOWN, 32'h0,        4'd0,  TYPED, '{STATUS_OK, 32'h0, 5'd0, 5'd14}},
      '{REQ_READ,    32'h0,        4'd14, TYPED, '{STATUS_BAD_INDEX, 32'h0, 5'd0, 5'd14}}
   };

   sorted_table_insert_erase_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_item_value    (req_item_value),
      .req_item_index    (req_item_index),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_item_position (rsp_item_position),
      .rsp_stored_count  (rsp_stored_count)
   );

   always #5 clock = ~clock;

   // Applies one request to the mirrored table and returns the result it should produce.
   function automatic table_result_type apply_table_request(input logic [1:0] kind,
                                                            input value_type value,
                                                            input logic [3:0] index);
      table_result_type res;
      int slot;
      res = '0;
      res.status = STATUS_OK;
      case (kind)
         REQ_INSERT: begin
            if (table_count >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               slot = 0;
               while (slot < table_count && table_entries[slot] <= value)
                  slot++;
               for (int i = table_count; i > slot; i--)
                  table_entries[i] = table_entries[i - 1];
               table_entries[slot] = value;
               table_count++;
               res.position = count_type'(slot);
            end
         end
         REQ_ERASE: begin
            if (int'(index) >= table_count) begin
               res.status = STATUS_BAD_INDEX;
            end else begin
               for (int i = index; i + 1 < table_count; i++)
                  table_entries[i] = table_entries[i + 1];
               table_count--;
               res.position = count_type'(index);
            end
         end
         REQ_READ: begin
            if (int'(index) >= table_count)
               res.status = STATUS_BAD_INDEX;
            else
               res.read_value = table_entries[index];
         end
         default: begin
         end
      endcase
      res.count = count_type'(table_count);
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic value_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      // Small values give plenty of duplicates, which exercise the after-equal placement.
      if (r < 30)
         return value_type'($urandom_range(0, 7));
      else if (r < 42)
         case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return 32'h80000000;
            default: return 32'h7FFFFFFF;
         endcase
      else
         return value_type'($urandom);
   endfunction

   function automatic logic [3:0] pick_index();
      if (table_count > 0 && $urandom_range(0, 99) < 85)
         return 4'($urandom_range(0, table_count - 1));
      else
         return 4'($urandom_range(0, 15));
   endfunction

   task automatic send_request(input logic [1:0] kind, input value_type value,
                               input logic [3:0] index, input bit typed,
                               input table_result_type known);
      table_result_type predicted;
      start <= 1'b1;
      req_type <= kind;
      req_item_value <= value;
      req_item_index <= index;
      do
         @(posedge clock);
      while (!(start && !busy));
      predicted = apply_table_request(kind, value, index);
      pending_results.push_back(typed ? known : predicted);
   endtask

   task automatic idle_for(input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_table_insert_erase_top regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_status !== oldest_result.status) begin
               $error("rsp_status: expected %0d, got %0d", oldest_result.status, rsp_status);
               error_count++;
            end
            if (rsp_read_value !== oldest_result.read_value) begin
               $error("rsp_read_value: expected %h, got %h",
                      oldest_result.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_item_position !== oldest_result.position) begin
               $error("rsp_item_position: expected %0d, got %0d",
                      oldest_result.position, rsp_item_position);
               error_count++;
            end
            if (rsp_stored_count !== oldest_result.count) begin
               $error("rsp_stored_count: expected %0d, got %0d",
                      oldest_result.count, rsp_stored_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      traffic_mode_type mode;
      int issued;
      int burst_left;
      int r;
      logic [1:0] kind;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_request(directed_rows[row].kind, directed_rows[row].value,
                      directed_rows[row].index, directed_rows[row].typed,
                      directed_rows[row].known);
         idle_for(pick_gap());
      end
      wait_for_results();

      mode = FILL_UP;
      issued = 0;
      burst_left = 0;
      while (issued < RANDOM_REQUESTS) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            kind = REQ_UNKNOWN;
         end else begin
            r = $urandom_range(0, 99);
            case (mode)
               FILL_UP:    kind = (r < 75) ? REQ_INSERT : (r < 88) ? REQ_READ : REQ_ERASE;
               DRAIN_DOWN: kind = (r < 70) ? REQ_ERASE : (r < 88) ? REQ_READ : REQ_INSERT;
               default:    kind = (r < 35) ? REQ_INSERT : (r < 70) ? REQ_ERASE : REQ_READ;
            endcase
            issued++;
         end
         send_request(kind, pick_value(), pick_index(), PREDICTED, '0);

         // Linger a little at the full and empty ends so the error paths get traffic.
         if ((mode == FILL_UP && table_count == DEPTH && $urandom_range(0, 99) < 30) ||
             (mode == DRAIN_DOWN && table_count == 0 && $urandom_range(0, 99) < 40) ||
             (mode == CHURN && $urandom_range(0, 99) < 2)) begin
            case ($urandom_range(0, 2))
               0: mode = FILL_UP;
               1: mode = DRAIN_DOWN;
               default: mode = CHURN;
            endcase
            if ($urandom_range(0, 9) == 0)
               wait_for_results();
         end

         if (burst_left > 0) begin
            burst_left--;
         end else if ($urandom_range(0, 199) == 0) begin
            burst_left = $urandom_range(20, 60);
         end else begin
            idle_for(pick_gap());
         end
      end

      wait_for_results();
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("sorted_table_insert_erase_top regression: pass");
      else
         $display("sorted_table_insert_erase_top regression: fail");
      $finish;
   end

endmodule
